>>> rtl/core/spt_pkg.sv
// Package for the sparse polynomial term table: sizes, field codes and the
// structs that travel between the control and the chain of term cells.
// No dependencies.
package spt_pkg;

    // Table size and width of a stored power.
    localparam int MAX_TERMS  = 16;
    localparam int POWER_BITS = 16;

    // Widths fixed by the stream fields.
    localparam int KIND_W    = 3;
    localparam int IN_POW_W  = 16;
    localparam int COEFF_W   = 32;
    localparam int OUT_POW_W = 16;
    localparam int TOTAL_W   = 5;
    localparam int STATUS_W  = 3;

    // Term counter holds 0 up to MAX_TERMS.
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_BITS = IN_POW_W + COEFF_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = COEFF_W + OUT_POW_W + TOTAL_W + STATUS_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_SET   = 3'd0,
        KIND_ADD   = 3'd1,
        KIND_SUB   = 3'd2,
        KIND_QUERY = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED   = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOOK   = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_UPDATE = 3'd4,
        CELL_CLEAR  = 3'd5
    } cell_op_t;

    // Broadcast control: operation, addressed power and new coefficient.
    typedef struct packed {
        cell_op_t                      op;
        logic [POWER_BITS-1:0]         power;
        logic signed [COEFF_W-1:0]     coeff;
    } cell_ctrl_t;

    // What one cell shows to its neighbors and to the control.
    typedef struct packed {
        logic                          occ;
        logic                          gt;
        logic                          eq;
        logic [POWER_BITS-1:0]         power;
        logic signed [COEFF_W-1:0]     coeff;
    } cell_view_t;

endpackage

>>> rtl/core/spt_cell.sv
// One cell of the term chain: holds one term and its lookup flags, and
// shifts terms with its neighbors on insert and remove. Depends on spt_pkg.
module spt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spt_pkg::cell_ctrl_t ctrl,
    input  spt_pkg::cell_view_t left,
    input  spt_pkg::cell_view_t right,
    output spt_pkg::cell_view_t view
);
    import spt_pkg::*;

    logic                      occ_reg, occ_next;
    logic                      gt_reg, gt_next;
    logic                      eq_reg, eq_next;
    logic [POWER_BITS-1:0]     power_reg, power_next;
    logic signed [COEFF_W-1:0] coeff_reg, coeff_next;

    // Next-state selection for the broadcast operation.
    always_comb
    begin
        occ_next   = occ_reg;
        gt_next    = gt_reg;
        eq_next    = eq_reg;
        power_next = power_reg;
        coeff_next = coeff_reg;
        case (ctrl.op)
            CELL_LOOK:
            begin
                // Compare this term with the addressed power.
                gt_next = occ_reg && (power_reg > ctrl.power);
                eq_next = occ_reg && (power_reg == ctrl.power);
            end
            CELL_INSERT:
            begin
                // Cells above the insertion point hold; the first cell not
                // above takes the new term, the rest take their left neighbor.
                if (!gt_reg)
                begin
                    if (left.gt)
                    begin
                        occ_next   = 1'b1;
                        power_next = ctrl.power;
                        coeff_next = ctrl.coeff;
                    end
                    else
                    begin
                        occ_next   = left.occ;
                        power_next = left.power;
                        coeff_next = left.coeff;
                    end
                end
            end
            CELL_REMOVE:
            begin
                // The matching cell and all after it take their right neighbor.
                if (!gt_reg)
                begin
                    occ_next   = right.occ;
                    power_next = right.power;
                    coeff_next = right.coeff;
                end
            end
            CELL_UPDATE:
            begin
                if (eq_reg)
                begin
                    coeff_next = ctrl.coeff;
                end
            end
            CELL_CLEAR:
            begin
                occ_next = 1'b0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // Control flags under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            gt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            gt_reg  <= gt_next;
            eq_reg  <= eq_next;
        end
    end

    // Term payload.
    always_ff @(posedge clk)
    begin
        power_reg <= power_next;
        coeff_reg <= coeff_next;
    end

    assign view.occ   = occ_reg;
    assign view.gt    = gt_reg;
    assign view.eq    = eq_reg;
    assign view.power = power_reg;
    assign view.coeff = coeff_reg;

endmodule

>>> rtl/core/sparse_polynomial_term_table.sv
// Top level of the sparse polynomial term table: control sequencer, output
// register and the chain of term cells. Depends on spt_pkg and spt_cell.
//
// The block keeps up to MAX_TERMS nonzero terms of one polynomial, sorted by
// descending power, in a chain of cells. Each request sets, adds to,
// subtracts from or queries the coefficient at one power (signed Q16.16,
// saturating), or clears the table, and returns exactly one result. A request
// holds the sequencer as it passes its states in order: IDLE takes it in,
// LOOK has all cells compare their power in parallel, CALC forms the new
// coefficient and decides the action, APPLY has the cells update or shift,
// and REPORT loads the result register that drives the master side.
// The next request is accepted once the previous one has left the sequencer,
// even while its result still waits in the output register; a result that is
// still waiting when the next one is ready holds the sequencer until it goes.
module sparse_polynomial_term_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] term_power, [47:16] coeff_in
    input  logic [spt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] kind
    input  logic [spt_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] coeff_out, [47:32] highest_power, [52:48] term_total,
    // [55:53] status
    output logic [spt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import spt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOK   = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_REPORT = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [KIND_W-1:0]         kind_reg;
    logic [POWER_BITS-1:0]     power_reg;
    logic signed [COEFF_W-1:0] operand_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    cell_op_t                  act_reg, act_next;
    logic signed [COEFF_W-1:0] res_reg, res_next;
    status_t                   status_reg, status_next;
    logic                      out_valid_reg;
    logic signed [COEFF_W-1:0] out_coeff_reg;
    logic [OUT_POW_W-1:0]      out_power_reg;
    logic [TOTAL_W-1:0]        out_total_reg;
    status_t                   out_status_reg;

    cell_ctrl_t                ctrl;
    cell_view_t                views [0:MAX_TERMS+1];
    logic [MAX_TERMS-1:0]      occ_vec;
    logic [MAX_TERMS-1:0]      gt_vec;
    logic [MAX_TERMS-1:0]      eq_vec;
    logic                      found;
    logic signed [COEFF_W-1:0] old_coeff;
    logic                      full;
    logic signed [COEFF_W:0]   sum_wide;
    logic signed [COEFF_W-1:0] new_val;
    logic                      accept;
    logic                      out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(MAX_TERMS));

    // Boundary views: before the first cell everything counts as above the
    // addressed power, after the last cell nothing is occupied.
    assign views[0]           = '{occ: 1'b1, gt: 1'b1, eq: 1'b0, power: '0, coeff: '0};
    assign views[MAX_TERMS+1] = '{occ: 1'b0, gt: 1'b0, eq: 1'b0, power: '0, coeff: '0};

    // The chain of term cells.
    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        spt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (views[i]),
            .right (views[i+2]),
            .view  (views[i+1])
        );
        assign occ_vec[i] = views[i+1].occ;
        assign gt_vec[i]  = views[i+1].gt;
        assign eq_vec[i]  = views[i+1].eq;
    end

    // Pick the coefficient of the matching cell; at most one cell matches.
    always_comb
    begin
        old_coeff = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            if (views[i+1].eq)
            begin
                old_coeff = old_coeff | views[i+1].coeff;
            end
        end
    end
    assign found = |eq_vec;

    // Set passes the operand; add or subtract saturates against the stored coefficient.
    always_comb
    begin
        if (kind_reg == KIND_SUB)
        begin
            sum_wide = {old_coeff[COEFF_W-1], old_coeff}
                     - {operand_reg[COEFF_W-1], operand_reg};
        end
        else
        begin
            sum_wide = {old_coeff[COEFF_W-1], old_coeff}
                     + {operand_reg[COEFF_W-1], operand_reg};
        end
        if (kind_reg == KIND_SET)
        begin
            new_val = operand_reg;
        end
        else if (sum_wide[COEFF_W] != sum_wide[COEFF_W-1])
        begin
            new_val = sum_wide[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                        : {1'b0, {(COEFF_W-1){1'b1}}};
        end
        else
        begin
            new_val = sum_wide[COEFF_W-1:0];
        end
    end

    // Decide the table action, result and status of the request.
    always_comb
    begin
        act_next    = CELL_HOLD;
        res_next    = '0;
        status_next = STAT_UPDATED;
        case (kind_reg)
            KIND_CLEAR:
            begin
                act_next = CELL_CLEAR;
            end
            KIND_SET, KIND_ADD, KIND_SUB:
            begin
                if (new_val == '0)
                begin
                    act_next    = found ? CELL_REMOVE : CELL_HOLD;
                    status_next = found ? STAT_REMOVED : STAT_NOT_FOUND;
                end
                else if (found)
                begin
                    act_next = CELL_UPDATE;
                    res_next = new_val;
                end
                else if (!full)
                begin
                    act_next    = CELL_INSERT;
                    res_next    = new_val;
                    status_next = STAT_INSERTED;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            default:
            begin
                // Query, and unused kinds behave as a query.
                res_next    = old_coeff;
                status_next = found ? STAT_UPDATED : STAT_NOT_FOUND;
            end
        endcase
    end

    // Broadcast to the cells.
    always_comb
    begin
        ctrl.power = power_reg;
        ctrl.coeff = res_reg;
        case (state_reg)
            ST_LOOK:  ctrl.op = CELL_LOOK;
            ST_APPLY: ctrl.op = act_reg;
            default:  ctrl.op = CELL_HOLD;
        endcase
    end

    // Term count follows the applied action.
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == ST_APPLY)
        begin
            case (act_reg)
                CELL_CLEAR:  count_next = '0;
                CELL_INSERT: count_next = count_reg + CNT_W'(1);
                CELL_REMOVE: count_next = count_reg - CNT_W'(1);
                default:     count_next = count_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_CALC;
            ST_CALC:   state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_REPORT;
            ST_REPORT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_REPORT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, decision and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_tuser;
            power_reg   <= POWER_BITS'(s_tdata[IN_POW_W-1:0]);
            operand_reg <= s_tdata[IN_POW_W+COEFF_W-1:IN_POW_W];
        end
        if (state_reg == ST_CALC)
        begin
            act_reg    <= act_next;
            res_reg    <= res_next;
            status_reg <= status_next;
        end
        if (state_reg == ST_REPORT && out_free)
        begin
            out_coeff_reg  <= res_reg;
            out_power_reg  <= (count_reg != '0) ? OUT_POW_W'(views[1].power) : '0;
            out_total_reg  <= TOTAL_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_status_reg, out_total_reg, out_power_reg,
                                  out_coeff_reg});

    // Occupied cells always match the term count.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == 32'(count_reg))
        else $error("occupied cells disagree with term count");

    // Occupied cells form a prefix of the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + MAX_TERMS'(1)) & occ_vec) == '0)
        else $error("occupied cells are not contiguous");

    // At most one cell matches the addressed power.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("more than one cell matches a power");

    // Cells above the addressed power form a prefix of the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((gt_vec + MAX_TERMS'(1)) & gt_vec) == '0)
        else $error("table order broken");

    // An insert is applied only while a cell is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && act_reg == CELL_INSERT) |-> !full)
        else $error("insert into full table");

endmodule
